>>> sv/dpwp_pkg.sv
package dpwp_pkg;

  // Default values for the top-level parameters.
  localparam int COORD_BITS_DEF = 12;
  localparam int DEPTH_BITS_DEF = 16;

  // Fixed widths of the configuration port and of the data fields.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 63;
  localparam int PRINCIPAL_W = 16;
  localparam int INV_W       = 24;
  localparam int INV_SPLIT   = 12;
  localparam int CAM_FRAC    = 24;
  localparam int ROT_W       = 16;
  localparam int ROT_FRAC    = 14;
  localparam int TRANS_W     = 21;
  localparam int CAM_SPLIT   = 17;
  localparam int OUT_W       = 32;
  localparam int COLOR_W     = 24;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PRINCIPAL_POINT = 3'd0,
    REG_INVERSE_FOCAL_X = 3'd1,
    REG_INVERSE_FOCAL_Y = 3'd2,
    REG_ROTATION_ROW_0  = 3'd3,
    REG_ROTATION_ROW_1  = 3'd4,
    REG_ROTATION_ROW_2  = 3'd5,
    REG_TRANSLATION     = 3'd6
  } cfg_reg_t;

  // Identity rotation after reset, one Q2.14 one on the diagonal.
  localparam logic [3*ROT_W-1:0] ROT_ROW0_RESET = 48'h0000_0000_4000;
  localparam logic [3*ROT_W-1:0] ROT_ROW1_RESET = 48'h0000_4000_0000;
  localparam logic [3*ROT_W-1:0] ROT_ROW2_RESET = 48'h4000_0000_0000;

  // Camera intrinsics as seen by the back-projection half.
  typedef struct packed {
    logic [PRINCIPAL_W-1:0] cx;
    logic [PRINCIPAL_W-1:0] cy;
    logic [INV_W-1:0]       inv_fx;
    logic [INV_W-1:0]       inv_fy;
  } intr_cfg_t;

  // Pose as seen by the transform half; rot[i][j] is row i, column j.
  typedef struct packed {
    logic [2:0][2:0][ROT_W-1:0] rot;
    logic [2:0][TRANS_W-1:0]    trans;
  } pose_cfg_t;

  // Width of the signed pixel offset u*16 - cx.
  function automatic int du_width(input int coord_bits);
    return ((coord_bits + 4 > PRINCIPAL_W) ? coord_bits + 4 : PRINCIPAL_W) + 1;
  endfunction

  // Width of the signed camera-space x and y coordinates.
  function automatic int cam_width(input int coord_bits, input int depth_bits);
    return du_width(coord_bits) + depth_bits + 3;
  endfunction

endpackage

>>> sv/depth_pixel_to_world_point.sv
// Channel   Direction  Handshake                  Word
// pixel     in         pixel_valid / pixel_stall  pixel_column, pixel_row, depth_value, pixel_color
// point     out        point_valid / point_stall  world_x, world_y, world_z, point_color
// config    in         cfg_write                  cfg_index, cfg_data
//
// One word per cycle sustained while point_stall stays low. The pipeline has eight
// register stages: offset, depth product, focal product, round, rotation products,
// column join, row sum, translate and saturate.
// Reset clears every stage valid bit and loads the identity pose and zero intrinsics.
// Each stage holds its word under stall and takes a new one once its word moves on,
// so empty stages close up and nothing is dropped or repeated.
module depth_pixel_to_world_point #(
  parameter int COORD_BITS = dpwp_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS = dpwp_pkg::DEPTH_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [dpwp_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [dpwp_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   pixel_valid,
  output logic                                   pixel_stall,
  input  logic [COORD_BITS-1:0]                  pixel_column,
  input  logic [COORD_BITS-1:0]                  pixel_row,
  input  logic [DEPTH_BITS-1:0]                  depth_value,
  input  logic [dpwp_pkg::COLOR_W-1:0]           pixel_color,
  output logic                                   point_valid,
  input  logic                                   point_stall,
  output logic signed [dpwp_pkg::OUT_W-1:0]      world_x,
  output logic signed [dpwp_pkg::OUT_W-1:0]      world_y,
  output logic signed [dpwp_pkg::OUT_W-1:0]      world_z,
  output logic [dpwp_pkg::COLOR_W-1:0]           point_color
);

  localparam int CAM_W = dpwp_pkg::cam_width(COORD_BITS, DEPTH_BITS);

  // Configuration registers.
  logic [2*dpwp_pkg::PRINCIPAL_W-1:0] principal_point;
  logic [dpwp_pkg::INV_W-1:0]         inverse_focal_x;
  logic [dpwp_pkg::INV_W-1:0]         inverse_focal_y;
  logic [3*dpwp_pkg::ROT_W-1:0]       rotation_row_zero;
  logic [3*dpwp_pkg::ROT_W-1:0]       rotation_row_one;
  logic [3*dpwp_pkg::ROT_W-1:0]       rotation_row_two;
  logic [3*dpwp_pkg::TRANS_W-1:0]     translation_packed;

  dpwp_pkg::intr_cfg_t                intr;
  dpwp_pkg::pose_cfg_t                pose;

  // Link between the two halves.
  logic                               cam_valid;
  logic                               cam_stall;
  logic signed [CAM_W-1:0]            cam_x;
  logic signed [CAM_W-1:0]            cam_y;
  logic [DEPTH_BITS-1:0]              cam_depth;
  logic [dpwp_pkg::COLOR_W-1:0]       cam_color;

  // Register writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      principal_point    <= '0;
      inverse_focal_x    <= '0;
      inverse_focal_y    <= '0;
      rotation_row_zero  <= dpwp_pkg::ROT_ROW0_RESET;
      rotation_row_one   <= dpwp_pkg::ROT_ROW1_RESET;
      rotation_row_two   <= dpwp_pkg::ROT_ROW2_RESET;
      translation_packed <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        dpwp_pkg::REG_PRINCIPAL_POINT: begin
          principal_point <= cfg_data[2*dpwp_pkg::PRINCIPAL_W-1:0];
        end
        dpwp_pkg::REG_INVERSE_FOCAL_X: begin
          inverse_focal_x <= cfg_data[dpwp_pkg::INV_W-1:0];
        end
        dpwp_pkg::REG_INVERSE_FOCAL_Y: begin
          inverse_focal_y <= cfg_data[dpwp_pkg::INV_W-1:0];
        end
        dpwp_pkg::REG_ROTATION_ROW_0: begin
          rotation_row_zero <= cfg_data[3*dpwp_pkg::ROT_W-1:0];
        end
        dpwp_pkg::REG_ROTATION_ROW_1: begin
          rotation_row_one <= cfg_data[3*dpwp_pkg::ROT_W-1:0];
        end
        dpwp_pkg::REG_ROTATION_ROW_2: begin
          rotation_row_two <= cfg_data[3*dpwp_pkg::ROT_W-1:0];
        end
        dpwp_pkg::REG_TRANSLATION: begin
          translation_packed <= cfg_data[3*dpwp_pkg::TRANS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Unpack the registers into the views each half needs.
  always_comb begin
    intr.cx     = principal_point[dpwp_pkg::PRINCIPAL_W-1:0];
    intr.cy     = principal_point[2*dpwp_pkg::PRINCIPAL_W-1:dpwp_pkg::PRINCIPAL_W];
    intr.inv_fx = inverse_focal_x;
    intr.inv_fy = inverse_focal_y;
    pose.rot[0] = rotation_row_zero;
    pose.rot[1] = rotation_row_one;
    pose.rot[2] = rotation_row_two;
    pose.trans  = translation_packed;
  end

  // Pixel to camera space.
  dpwp_backproject #(
    .COORD_BITS (COORD_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_backproject (
    .clk          (clk),
    .rst          (rst),
    .intr         (intr),
    .in_valid     (pixel_valid),
    .in_stall     (pixel_stall),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .depth_value  (depth_value),
    .pixel_color  (pixel_color),
    .out_valid    (cam_valid),
    .out_stall    (cam_stall),
    .cam_x        (cam_x),
    .cam_y        (cam_y),
    .cam_depth    (cam_depth),
    .cam_color    (cam_color)
  );

  // Camera space to world space.
  dpwp_transform #(
    .COORD_BITS (COORD_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_transform (
    .clk         (clk),
    .rst         (rst),
    .pose        (pose),
    .in_valid    (cam_valid),
    .in_stall    (cam_stall),
    .cam_x       (cam_x),
    .cam_y       (cam_y),
    .cam_depth   (cam_depth),
    .cam_color   (cam_color),
    .out_valid   (point_valid),
    .out_stall   (point_stall),
    .world_x     (world_x),
    .world_y     (world_y),
    .world_z     (world_z),
    .point_color (point_color)
  );

endmodule

>>> sv/dpwp_backproject.sv
module dpwp_backproject #(
  parameter int COORD_BITS = dpwp_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS = dpwp_pkg::DEPTH_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  dpwp_pkg::intr_cfg_t                    intr,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [COORD_BITS-1:0]                  pixel_column,
  input  logic [COORD_BITS-1:0]                  pixel_row,
  input  logic [DEPTH_BITS-1:0]                  depth_value,
  input  logic [dpwp_pkg::COLOR_W-1:0]           pixel_color,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [dpwp_pkg::cam_width(COORD_BITS, DEPTH_BITS)-1:0] cam_x,
  output logic signed [dpwp_pkg::cam_width(COORD_BITS, DEPTH_BITS)-1:0] cam_y,
  output logic [DEPTH_BITS-1:0]                  cam_depth,
  output logic [dpwp_pkg::COLOR_W-1:0]           cam_color
);

  localparam int DU_W   = dpwp_pkg::du_width(COORD_BITS);
  localparam int PZ_W   = DU_W + DEPTH_BITS + 1;
  localparam int SPL    = dpwp_pkg::INV_SPLIT;
  localparam int PP_W   = PZ_W + SPL + 1;
  localparam int FRAC   = dpwp_pkg::CAM_FRAC;
  localparam int FULL_W = PP_W + SPL + 1;
  localparam int CAM_W  = FULL_W - FRAC;
  localparam logic [FULL_W-1:0] CAM_HALF =
    {{(FULL_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

  // Stage valid bits and per-stage ready.
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  // Stage payload registers.
  logic signed [DU_W-1:0]        du_x1, du_y1;
  logic [DEPTH_BITS-1:0]         z1, z2, z3, z4;
  logic [dpwp_pkg::COLOR_W-1:0]  color1, color2, color3, color4;
  logic signed [PZ_W-1:0]        pz_x2, pz_y2;
  logic signed [PP_W-1:0]        ph_x3, pl_x3, ph_y3, pl_y3;
  logic signed [CAM_W-1:0]       cam_x4, cam_y4;

  // Next values.
  logic [DU_W-1:0]               u_ext, v_ext, cx_ext, cy_ext;
  logic signed [DU_W-1:0]        du_x_next, du_y_next;
  logic signed [DEPTH_BITS:0]    z_signed;
  logic signed [PZ_W-1:0]        pz_x_next, pz_y_next;
  logic signed [SPL:0]           fx_lo, fx_hi, fy_lo, fy_hi;
  logic signed [PP_W-1:0]        ph_x_next, pl_x_next, ph_y_next, pl_y_next;
  logic signed [FULL_W-1:0]      hx_ext, lx_ext, hy_ext, ly_ext;
  logic signed [FULL_W-1:0]      full_x, full_y;

  // A stage takes a new word when it is empty or its word moves on.
  assign rdy4     = !v4 || !out_stall;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  // Pixel offsets from the principal point, in Q.4.
  always_comb begin
    u_ext     = {{(DU_W-COORD_BITS-4){1'b0}}, pixel_column, 4'b0000};
    v_ext     = {{(DU_W-COORD_BITS-4){1'b0}}, pixel_row, 4'b0000};
    cx_ext    = {{(DU_W-dpwp_pkg::PRINCIPAL_W){1'b0}}, intr.cx};
    cy_ext    = {{(DU_W-dpwp_pkg::PRINCIPAL_W){1'b0}}, intr.cy};
    du_x_next = $signed(u_ext - cx_ext);
    du_y_next = $signed(v_ext - cy_ext);
  end

  // Offset times depth.
  always_comb begin
    z_signed  = $signed({1'b0, z1});
    pz_x_next = du_x1 * z_signed;
    pz_y_next = du_y1 * z_signed;
  end

  // Product times reciprocal focal length, split in two 12-bit halves.
  always_comb begin
    fx_lo     = $signed({1'b0, intr.inv_fx[SPL-1:0]});
    fx_hi     = $signed({1'b0, intr.inv_fx[2*SPL-1:SPL]});
    fy_lo     = $signed({1'b0, intr.inv_fy[SPL-1:0]});
    fy_hi     = $signed({1'b0, intr.inv_fy[2*SPL-1:SPL]});
    ph_x_next = pz_x2 * fx_hi;
    pl_x_next = pz_x2 * fx_lo;
    ph_y_next = pz_y2 * fy_hi;
    pl_y_next = pz_y2 * fy_lo;
  end

  // Join the halves, round half up and drop the 24 fraction bits.
  always_comb begin
    hx_ext = ph_x3;
    lx_ext = pl_x3;
    hy_ext = ph_y3;
    ly_ext = pl_y3;
    full_x = (hx_ext <<< SPL) + lx_ext + $signed(CAM_HALF);
    full_y = (hy_ext <<< SPL) + ly_ext + $signed(CAM_HALF);
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      du_x1  <= du_x_next;
      du_y1  <= du_y_next;
      z1     <= depth_value;
      color1 <= pixel_color;
    end
    if (rdy2) begin
      pz_x2  <= pz_x_next;
      pz_y2  <= pz_y_next;
      z2     <= z1;
      color2 <= color1;
    end
    if (rdy3) begin
      ph_x3  <= ph_x_next;
      pl_x3  <= pl_x_next;
      ph_y3  <= ph_y_next;
      pl_y3  <= pl_y_next;
      z3     <= z2;
      color3 <= color2;
    end
    if (rdy4) begin
      cam_x4 <= full_x[FULL_W-1:FRAC];
      cam_y4 <= full_y[FULL_W-1:FRAC];
      z4     <= z3;
      color4 <= color3;
    end
  end

  assign out_valid = v4;
  assign cam_x     = cam_x4;
  assign cam_y     = cam_y4;
  assign cam_depth = z4;
  assign cam_color = color4;

`ifndef SYNTH
  // Reset empties every stage.
  assert property (@(posedge clk) rst |=> !(v1 || v2 || v3 || v4))
    else $error("back-projection stages not empty after reset");

  // A held word at the last stage keeps its coordinates.
  assert property (@(posedge clk) disable iff (rst)
    v4 && out_stall |=> v4 && $stable(cam_x4) && $stable(cam_y4))
    else $error("camera point changed while held");

  // Zero depth gives zero offset-depth products.
  assert property (@(posedge clk) disable iff (rst)
    v1 && rdy2 && z1 == '0 |=> pz_x2 == '0 && pz_y2 == '0)
    else $error("zero depth did not clear the camera product");
`endif

endmodule

>>> sv/dpwp_transform.sv
module dpwp_transform #(
  parameter int COORD_BITS = dpwp_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS = dpwp_pkg::DEPTH_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  dpwp_pkg::pose_cfg_t                    pose,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [dpwp_pkg::cam_width(COORD_BITS, DEPTH_BITS)-1:0] cam_x,
  input  logic signed [dpwp_pkg::cam_width(COORD_BITS, DEPTH_BITS)-1:0] cam_y,
  input  logic [DEPTH_BITS-1:0]                  cam_depth,
  input  logic [dpwp_pkg::COLOR_W-1:0]           cam_color,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [dpwp_pkg::OUT_W-1:0]      world_x,
  output logic signed [dpwp_pkg::OUT_W-1:0]      world_y,
  output logic signed [dpwp_pkg::OUT_W-1:0]      world_z,
  output logic [dpwp_pkg::COLOR_W-1:0]           point_color
);

  localparam int CAM_W  = dpwp_pkg::cam_width(COORD_BITS, DEPTH_BITS);
  localparam int RW     = dpwp_pkg::ROT_W;
  localparam int SPL    = dpwp_pkg::CAM_SPLIT;
  localparam int HI_W   = CAM_W - SPL;
  localparam int RH_W   = RW + HI_W;
  localparam int RL_W   = RW + SPL + 1;
  localparam int ZC_W   = DEPTH_BITS + 5;
  localparam int RZ_W   = RW + ZC_W;
  localparam int COL_W  = RW + CAM_W + 1;
  localparam int ACC_W  = ((COL_W > RZ_W) ? COL_W : RZ_W) + 2;
  localparam int FRAC   = dpwp_pkg::ROT_FRAC;
  localparam int SH_W   = ACC_W - FRAC;
  localparam int OW     = dpwp_pkg::OUT_W;
  localparam int W_W    = ((SH_W > OW) ? SH_W : OW) + 1;
  localparam logic [ACC_W-1:0] ROT_HALF =
    {{(ACC_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
  localparam logic [OW-1:0] SAT_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] SAT_MIN = {1'b1, {(OW-1){1'b0}}};

  // Stage valid bits and per-stage ready.
  logic v5, v6, v7, v8;
  logic rdy5, rdy6, rdy7, rdy8;

  // Stage payload registers.
  logic signed [RH_W-1:0]        ph5 [3][2];
  logic signed [RL_W-1:0]        pl5 [3][2];
  logic signed [RZ_W-1:0]        pz5 [3];
  logic signed [COL_W-1:0]       col6 [3][2];
  logic signed [RZ_W-1:0]        pz6 [3];
  logic signed [ACC_W-1:0]       acc7 [3];
  logic signed [OW-1:0]          world8 [3];
  logic [dpwp_pkg::COLOR_W-1:0]  color5, color6, color7, color8;

  // Next values.
  logic signed [HI_W-1:0]        cam_hi [2];
  logic signed [SPL:0]           cam_lo [2];
  logic signed [ZC_W-1:0]        zc;
  logic signed [RH_W-1:0]        ph_next [3][2];
  logic signed [RL_W-1:0]        pl_next [3][2];
  logic signed [RZ_W-1:0]        pz_next [3];
  logic signed [COL_W-1:0]       col_next [3][2];
  logic signed [ACC_W-1:0]       acc_next [3];
  logic [OW-1:0]                 world_next [3];

  // A stage takes a new word when it is empty or its word moves on.
  assign rdy8     = !v8 || !out_stall;
  assign rdy7     = !v7 || rdy8;
  assign rdy6     = !v6 || rdy7;
  assign rdy5     = !v5 || rdy6;
  assign in_stall = !rdy5;

  // Rotation products; x and y are split in a signed high and an unsigned low part.
  always_comb begin
    cam_hi[0] = $signed(cam_x[CAM_W-1:SPL]);
    cam_hi[1] = $signed(cam_y[CAM_W-1:SPL]);
    cam_lo[0] = $signed({1'b0, cam_x[SPL-1:0]});
    cam_lo[1] = $signed({1'b0, cam_y[SPL-1:0]});
    zc        = $signed({1'b0, cam_depth, 4'b0000});
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 2; j++) begin
        ph_next[i][j] = $signed(pose.rot[i][j]) * cam_hi[j];
        pl_next[i][j] = $signed(pose.rot[i][j]) * cam_lo[j];
      end
      pz_next[i] = $signed(pose.rot[i][2]) * zc;
    end
  end

  // Rebuild each x and y column term from its two parts.
  always_comb begin
    logic signed [COL_W-1:0] hi_ext;
    logic signed [COL_W-1:0] lo_ext;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 2; j++) begin
        hi_ext         = ph5[i][j];
        lo_ext         = pl5[i][j];
        col_next[i][j] = (hi_ext <<< SPL) + lo_ext;
      end
    end
  end

  // Row sums with the rounding half added.
  always_comb begin
    logic signed [ACC_W-1:0] c0_ext;
    logic signed [ACC_W-1:0] c1_ext;
    logic signed [ACC_W-1:0] c2_ext;
    for (int i = 0; i < 3; i++) begin
      c0_ext      = col6[i][0];
      c1_ext      = col6[i][1];
      c2_ext      = pz6[i];
      acc_next[i] = c0_ext + c1_ext + c2_ext + $signed(ROT_HALF);
    end
  end

  // Drop the rotation fraction, add the translation and saturate.
  always_comb begin
    logic signed [W_W-1:0] sh_ext;
    logic signed [W_W-1:0] t_ext;
    logic signed [W_W-1:0] w_sum;
    for (int i = 0; i < 3; i++) begin
      sh_ext = $signed(acc7[i][ACC_W-1:FRAC]);
      t_ext  = $signed(pose.trans[i]);
      w_sum  = sh_ext + (t_ext <<< 4);
      if (w_sum[W_W-1:OW-1] == '0 || w_sum[W_W-1:OW-1] == '1) begin
        world_next[i] = w_sum[OW-1:0];
      end else if (w_sum[W_W-1]) begin
        world_next[i] = SAT_MIN;
      end else begin
        world_next[i] = SAT_MAX;
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      if (rdy5) begin
        v5 <= in_valid;
      end
      if (rdy6) begin
        v6 <= v5;
      end
      if (rdy7) begin
        v7 <= v6;
      end
      if (rdy8) begin
        v8 <= v7;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rdy5) begin
      ph5    <= ph_next;
      pl5    <= pl_next;
      pz5    <= pz_next;
      color5 <= cam_color;
    end
    if (rdy6) begin
      col6   <= col_next;
      pz6    <= pz5;
      color6 <= color5;
    end
    if (rdy7) begin
      acc7   <= acc_next;
      color7 <= color6;
    end
    if (rdy8) begin
      for (int i = 0; i < 3; i++) begin
        world8[i] <= $signed(world_next[i]);
      end
      color8 <= color7;
    end
  end

  assign out_valid   = v8;
  assign world_x     = world8[0];
  assign world_y     = world8[1];
  assign world_z     = world8[2];
  assign point_color = color8;

`ifndef SYNTH
  // Reset empties every stage.
  assert property (@(posedge clk) rst |=> !(v5 || v6 || v7 || v8))
    else $error("transform stages not empty after reset");

  // A word that leaves the row-sum stage lands in the output stage.
  assert property (@(posedge clk) disable iff (rst) v7 && rdy8 |=> v8)
    else $error("word lost between row sum and output");

  // A held result keeps its coordinates and color.
  assert property (@(posedge clk) disable iff (rst)
    v8 && out_stall |=> v8 && $stable(world8[0]) && $stable(world8[1])
      && $stable(world8[2]) && $stable(color8))
    else $error("world point changed while held");
`endif

endmodule

>>> dv/tb_depth_pixel_to_world_point.sv
`timescale 1ns / 100ps

module tb_depth_pixel_to_world_point;

  localparam int COORD_W = dpwp_pkg::COORD_BITS_DEF;
  localparam int DEPTH_W = dpwp_pkg::DEPTH_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int NUM_PHASES = 8;
  localparam int WORDS_PER_PHASE = 210;
  localparam int NUM_ROWS = 23;

  // Index that decodes to no register; writes to it must be dropped.
  localparam logic [dpwp_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic signed [dpwp_pkg::OUT_W-1:0] WORLD_MIN = 32'sh8000_0000;
  localparam logic signed [dpwp_pkg::OUT_W-1:0] WORLD_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [dpwp_pkg::OUT_W-1:0] x;
    logic signed [dpwp_pkg::OUT_W-1:0] y;
    logic signed [dpwp_pkg::OUT_W-1:0] z;
    logic [dpwp_pkg::COLOR_W-1:0]      color;
  } point_t;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

  typedef struct {
    row_kind_t                         kind;
    logic [dpwp_pkg::CFG_INDEX_W-1:0]  index;
    logic [dpwp_pkg::CFG_DATA_W-1:0]   data;
    logic [COORD_W-1:0]                u;
    logic [COORD_W-1:0]                v;
    logic [DEPTH_W-1:0]                depth;
    logic [dpwp_pkg::COLOR_W-1:0]      color;
    bit                                typed;
    logic signed [dpwp_pkg::OUT_W-1:0] wx;
    logic signed [dpwp_pkg::OUT_W-1:0] wy;
    logic signed [dpwp_pkg::OUT_W-1:0] wz;
  } script_row_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_write = 1'b0;
  logic [dpwp_pkg::CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [dpwp_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
  logic                               pixel_valid = 1'b0;
  logic                               pixel_stall;
  logic [COORD_W-1:0]                 pixel_column = '0;
  logic [COORD_W-1:0]                 pixel_row = '0;
  logic [DEPTH_W-1:0]                 depth_value = '0;
  logic [dpwp_pkg::COLOR_W-1:0]       pixel_color = '0;
  logic                               point_valid;
  logic                               point_stall = 1'b0;
  logic signed [dpwp_pkg::OUT_W-1:0]  world_x;
  logic signed [dpwp_pkg::OUT_W-1:0]  world_y;
  logic signed [dpwp_pkg::OUT_W-1:0]  world_z;
  logic [dpwp_pkg::COLOR_W-1:0]       point_color;

  // Shadow copy of the camera and pose registers.
  logic [2*dpwp_pkg::PRINCIPAL_W-1:0] principal = '0;
  logic [dpwp_pkg::INV_W-1:0]         inv_focal_x = '0;
  logic [dpwp_pkg::INV_W-1:0]         inv_focal_y = '0;
  logic [3*dpwp_pkg::ROT_W-1:0]       rotation_rows [3] = '{dpwp_pkg::ROT_ROW0_RESET,
                                                            dpwp_pkg::ROT_ROW1_RESET,
                                                            dpwp_pkg::ROT_ROW2_RESET};
  logic [3*dpwp_pkg::TRANS_W-1:0]     translation = '0;

  point_t pending_points [$];
  int     mismatches = 0;
  int     quiet_cycles = 0;
  bit     steady_flow = 1'b0;

  // Directed words: reset pose, then saturating intrinsics, then an extreme pose.
  script_row_t script [NUM_ROWS] = '{
    '{ROW_PIXEL, '0, '0, 12'h000, 12'h000, 16'h0000, 24'h000000, 1'b1, 0, 0, 0},
    '{ROW_PIXEL, '0, '0, 12'hFFF, 12'hFFF, 16'hFFFF, 24'hFFFFFF, 1'b1, 0, 0, 1048560},
    '{ROW_PIXEL, '0, '0, 12'hAAA, 12'h555, 16'h5555, 24'hAA55AA, 1'b1, 0, 0, 32'h0005_5550},
    '{ROW_PIXEL, '0, '0, 12'h555, 12'hAAA, 16'hAAAA, 24'h55AA55, 1'b1, 0, 0, 32'h000A_AAA0},
    '{ROW_WRITE, dpwp_pkg::REG_PRINCIPAL_POINT, 63'h7FFF_FFFF_0000_FFFF,
      '0, '0, '0, '0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, dpwp_pkg::REG_INVERSE_FOCAL_X, 63'h7FFF_FFFF_FFFF_FFFF,
      '0, '0, '0, '0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, dpwp_pkg::REG_INVERSE_FOCAL_Y, 63'h7FFF_FFFF_FFFF_FFFF,
      '0, '0, '0, '0, 1'b0, 0, 0, 0},
    '{ROW_PIXEL, '0, '0, 12'h000, 12'hFFF, 16'hFFFF, 24'h123456, 1'b1,
      WORLD_MIN, WORLD_MAX, 1048560},
    '{ROW_PIXEL, '0, '0, 12'h000, 12'hFFF, 16'h0000, 24'h654321, 1'b1, 0, 0, 0},
    '{ROW_PIXEL, '0, '0, 12'hFFF, 12'h000, 16'hFFFF, 24'h0F0F0F, 1'b0, 0, 0, 0},
    '{ROW_PIXEL, '0, '0, 12'h800, 12'h800, 16'h0001, 24'hF0F0F0, 1'b0, 0, 0, 0},
    '{ROW_PIXEL, '0, '0, 12'h7FF, 12'h001, 16'h8000, 24'h3C3C3C, 1'b0, 0, 0, 0},
    '{ROW_WRITE, REG_UNUSED, 63'h7FFF_FFFF_FFFF_FFFF, '0, '0, '0, '0, 1'b0, 0, 0, 0},
    '{ROW_PIXEL, '0, '0, 12'h000, 12'hFFF, 16'h0000, 24'hC3C3C3, 1'b1, 0, 0, 0},
    '{ROW_WRITE, dpwp_pkg::REG_ROTATION_ROW_0, 63'h0000_8000_7FFF_8000,
      '0, '0, '0, '0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, dpwp_pkg::REG_ROTATION_ROW_1, 63'h0000_7FFF_8000_7FFF,
      '0, '0, '0, '0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, dpwp_pkg::REG_ROTATION_ROW_2, 63'h0000_8000_8000_8000,
      '0, '0, '0, '0, 1'b0, 0, 0, 0},
    '{ROW_WRITE, dpwp_pkg::REG_TRANSLATION, 63'h7FFF_FE00_000F_FFFF,
      '0, '0, '0, '0, 1'b0, 0, 0, 0},
    '{ROW_PIXEL, '0, '0, 12'h000, 12'hFFF, 16'h0000, 24'h00FF00, 1'b1,
      16777200, -16777216, -16},
    '{ROW_PIXEL, '0, '0, 12'h000, 12'h000, 16'hFFFF, 24'hFF00FF, 1'b0, 0, 0, 0},
    '{ROW_PIXEL, '0, '0, 12'hFFF, 12'hFFF, 16'hFFFF, 24'h0000FF, 1'b0, 0, 0, 0},
    '{ROW_PIXEL, '0, '0, 12'h000, 12'hFFF, 16'hFFFF, 24'hFF0000, 1'b0, 0, 0, 0},
    '{ROW_PIXEL, '0, '0, 12'h123, 12'h456, 16'h789A, 24'h5A5A5A, 1'b0, 0, 0, 0}
  };

  depth_pixel_to_world_point dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .depth_value  (depth_value),
    .pixel_color  (pixel_color),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .world_x      (world_x),
    .world_y      (world_y),
    .world_z      (world_z),
    .point_color  (point_color)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Round half up, then drop s fraction bits; the arithmetic shift floors.
  function automatic longint round_half_up(input longint p, input int s);
    return (p + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // Expected world point for one pixel under the current shadow registers.
  function automatic point_t project_pixel(input logic [COORD_W-1:0] u,
                                           input logic [COORD_W-1:0] v,
                                           input logic [DEPTH_W-1:0] d,
                                           input logic [dpwp_pkg::COLOR_W-1:0] c);
    longint cam [3];
    longint acc;
    longint sum;
    longint du;
    longint dv;
    logic signed [dpwp_pkg::OUT_W-1:0] w [3];
    point_t p;
    du = longint'(u) * 16 - longint'(principal[dpwp_pkg::PRINCIPAL_W-1:0]);
    dv = longint'(v) * 16
         - longint'(principal[2*dpwp_pkg::PRINCIPAL_W-1:dpwp_pkg::PRINCIPAL_W]);
    cam[0] = round_half_up(du * longint'(d) * longint'(inv_focal_x), dpwp_pkg::CAM_FRAC);
    cam[1] = round_half_up(dv * longint'(d) * longint'(inv_focal_y), dpwp_pkg::CAM_FRAC);
    cam[2] = longint'(d) * 16;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        acc += longint'($signed(rotation_rows[i][dpwp_pkg::ROT_W*j +: dpwp_pkg::ROT_W]))
               * cam[j];
      end
      sum = round_half_up(acc, dpwp_pkg::ROT_FRAC)
            + longint'($signed(translation[dpwp_pkg::TRANS_W*i +: dpwp_pkg::TRANS_W])) * 16;
      if (sum > longint'(WORLD_MAX)) begin
        sum = longint'(WORLD_MAX);
      end else if (sum < longint'(WORLD_MIN)) begin
        sum = longint'(WORLD_MIN);
      end
      w[i] = sum[dpwp_pkg::OUT_W-1:0];
    end
    p.x = w[0];
    p.y = w[1];
    p.z = w[2];
    p.color = c;
    return p;
  endfunction

  // Mirror a register write; unknown indexes change nothing.
  function automatic void load_register(input logic [dpwp_pkg::CFG_INDEX_W-1:0] idx,
                                        input logic [dpwp_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      dpwp_pkg::REG_PRINCIPAL_POINT: principal = val[2*dpwp_pkg::PRINCIPAL_W-1:0];
      dpwp_pkg::REG_INVERSE_FOCAL_X: inv_focal_x = val[dpwp_pkg::INV_W-1:0];
      dpwp_pkg::REG_INVERSE_FOCAL_Y: inv_focal_y = val[dpwp_pkg::INV_W-1:0];
      dpwp_pkg::REG_ROTATION_ROW_0:  rotation_rows[0] = val[3*dpwp_pkg::ROT_W-1:0];
      dpwp_pkg::REG_ROTATION_ROW_1:  rotation_rows[1] = val[3*dpwp_pkg::ROT_W-1:0];
      dpwp_pkg::REG_ROTATION_ROW_2:  rotation_rows[2] = val[3*dpwp_pkg::ROT_W-1:0];
      dpwp_pkg::REG_TRANSLATION:     translation = val[3*dpwp_pkg::TRANS_W-1:0];
      default: ;
    endcase
  endfunction

  // Idle or stall length for one word; zero throughout a steady phase.
  function automatic int draw_wait();
    if (steady_flow) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 18);
    return 0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Register write; the enable stays high when another write follows at once.
  task automatic write_register(input logic [dpwp_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [dpwp_pkg::CFG_DATA_W-1:0] val,
                                input bit last_in_batch);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    load_register(idx, val);
    if (last_in_batch) cfg_write <= 1'b0;
  endtask

  // Offer one pixel word after a random gap and log its expected point.
  task automatic send_pixel(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                            input logic [DEPTH_W-1:0] d,
                            input logic [dpwp_pkg::COLOR_W-1:0] c,
                            input bit typed, input point_t typed_point);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_column <= u;
    pixel_row <= v;
    depth_value <= d;
    pixel_color <= c;
    do @(posedge clk); while (pixel_stall !== 1'b0);
    pending_points.push_back(typed ? typed_point : project_pixel(u, v, d, c));
  endtask

  // Stop offering pixels and wait until every expected point has come out.
  task automatic drain_points();
    pixel_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  // Point sink: random stalls, then compare each accepted word with the oldest
  // expectation.
  initial begin : point_sink
    point_t want;
    int hold;
    @(negedge rst);
    forever begin
      hold = draw_wait();
      point_stall <= (hold != 0);
      repeat (hold) @(posedge clk);
      if (hold != 0) point_stall <= 1'b0;
      do @(posedge clk); while (point_valid !== 1'b1);
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("point word with no pixel pending: %0d %0d %0d %06h",
                                  world_x, world_y, world_z, point_color));
      end else begin
        want = pending_points.pop_front();
        if (world_x !== want.x)
          report_mismatch($sformatf("world_x got %0d expected %0d", world_x, want.x));
        if (world_y !== want.y)
          report_mismatch($sformatf("world_y got %0d expected %0d", world_y, want.y));
        if (world_z !== want.z)
          report_mismatch($sformatf("world_z got %0d expected %0d", world_z, want.z));
        if (point_color !== want.color)
          report_mismatch($sformatf("point_color got %06h expected %06h",
                                    point_color, want.color));
      end
    end
  end

  // Watchdog: end the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (point_valid && !point_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_depth_pixel_to_world_point failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int row;
    int phase;
    int k;
    dpwp_pkg::cfg_reg_t reg_id;
    logic [dpwp_pkg::CFG_DATA_W-1:0] val;
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
    logic [DEPTH_W-1:0] d;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed script; registers change only once the pipeline is empty.
    for (row = 0; row < NUM_ROWS; row++) begin
      if (script[row].kind == ROW_WRITE) begin
        if (row == 0 || script[row-1].kind != ROW_WRITE) drain_points();
        write_register(script[row].index, script[row].data,
                       row + 1 == NUM_ROWS || script[row+1].kind != ROW_WRITE);
      end else begin
        send_pixel(script[row].u, script[row].v, script[row].depth, script[row].color,
                   script[row].typed,
                   '{script[row].wx, script[row].wy, script[row].wz, script[row].color});
      end
    end

    // Random phases, each with a fresh register set; phase 1 is all ones and
    // phase 2 all zeros.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain_points();
      steady_flow = (phase == 3) || ($urandom_range(0, 4) == 0);
      reg_id = reg_id.first();
      do begin
        if (phase == 1) begin
          val = '1;
        end else if (phase == 2) begin
          val = '0;
        end else begin
          val = 63'({$urandom, $urandom});
          case (reg_id)
            dpwp_pkg::REG_PRINCIPAL_POINT:
              if ($urandom_range(0, 1) == 0)
                val = {31'b0, 16'($urandom_range(0, 65520)), 16'($urandom_range(0, 65520))};
            dpwp_pkg::REG_INVERSE_FOCAL_X, dpwp_pkg::REG_INVERSE_FOCAL_Y:
              if ($urandom_range(0, 1) == 0) val = 63'($urandom_range(8000, 90000));
            dpwp_pkg::REG_ROTATION_ROW_0, dpwp_pkg::REG_ROTATION_ROW_1,
            dpwp_pkg::REG_ROTATION_ROW_2:
              for (int e = 0; e < 3; e++) begin
                if ($urandom_range(0, 3) != 0)
                  val[dpwp_pkg::ROT_W*e +: dpwp_pkg::ROT_W] =
                    16'($urandom_range(0, 32768) - 16384);
              end
            default: ;
          endcase
        end
        write_register(reg_id, val, reg_id == reg_id.last() && !phase[0]);
        reg_id = reg_id.next();
      end while (reg_id != reg_id.first());
      if (phase[0]) write_register(REG_UNUSED, 63'({$urandom, $urandom}), 1'b1);

      for (k = 0; k < WORDS_PER_PHASE; k++) begin
        // Hold off once mid-phase until the pipeline has emptied.
        if (phase == 4 && k == WORDS_PER_PHASE / 2) drain_points();
        u = ($urandom_range(0, 7) == 0) ? {COORD_W{$urandom_range(0, 1) == 1}}
                                        : COORD_W'($urandom);
        v = ($urandom_range(0, 7) == 0) ? {COORD_W{$urandom_range(0, 1) == 1}}
                                        : COORD_W'($urandom);
        case ($urandom_range(0, 7))
          0: d = '0;
          1: d = '1;
          2: d = DEPTH_W'($urandom_range(200, 8000));
          default: d = DEPTH_W'($urandom);
        endcase
        send_pixel(u, v, d, dpwp_pkg::COLOR_W'($urandom), 1'b0, '0);
      end
    end

    drain_points();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_depth_pixel_to_world_point passed");
    end else begin
      $display("tb_depth_pixel_to_world_point failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/dpwp_pkg.sv
sv/dpwp_backproject.sv
sv/dpwp_transform.sv
sv/depth_pixel_to_world_point.sv
dv/tb_depth_pixel_to_world_point.sv
